// ===== rtl/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg: shared types and constants of the gradient background pixel unit
// Field widths, register indexes, gradient coefficients, the reciprocal used
// for the floor division by 255, and the small fraction tables.
// ----------------------------------------------------------------------------
package gbp_pkg;

	localparam int unsigned CoordW  = 12;
	localparam int unsigned DimW    = 13;
	localparam int unsigned PitchW  = 16;
	localparam int unsigned WplW    = PitchW - 2;
	localparam int unsigned IdxW    = 26;
	localparam int unsigned ArgbW   = 32;
	localparam int unsigned ChanW   = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = PitchW;

	localparam int unsigned MaxDim  = 4096;
	localparam int unsigned NormMax = 255;

	// Normalized position: pos * 255 needs eight more bits than the coordinate.
	localparam int unsigned NormW   = CoordW + ChanW;
	// Restoring divider retires this many quotient bits per pipeline stage.
	localparam int unsigned DivBits = 2;
	localparam int unsigned NDiv    = NormW / DivBits;

	// floor(v / 255) == (v * RecipM) >> RecipSh for every v below 2^20.
	localparam int unsigned RecipM  = 1052689;
	localparam int unsigned RecipW  = 21;
	localparam int unsigned RecipSh = 28;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgLinePitch   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [DimW-1:0] RstWidth  = 13'd1024;
	localparam logic [DimW-1:0] RstHeight = 13'd768;
	localparam logic [WplW-1:0] RstWpl    = 14'd1024;

	// Gradient coefficients.
	localparam logic [ChanW-1:0] RedBase = 8'd255;
	localparam logic [ChanW-1:0] GrnBase = 8'd200;
	localparam logic [ChanW-1:0] BluBase = 8'd220;
	localparam logic [ChanW-1:0] RedY    = 8'd155;
	localparam logic [ChanW-1:0] RedX    = 8'd20;
	localparam logic [ChanW-1:0] GrnY    = 8'd100;
	localparam logic [ChanW-1:0] BluY    = 8'd20;
	localparam logic [ChanW-1:0] BluX    = 8'd35;
	localparam logic [ChanW-1:0] Alpha   = 8'hFF;

	typedef logic [ChanW-1:0] tbl_t [256];

	typedef struct packed {
		logic [DimW-1:0]  rem;
		logic [NormW-1:0] dq;
	} div_t;

	typedef struct packed {
		logic [IdxW-1:0] widx;
		logic            oor;
	} side_t;

	// floor(i * k / 255) for every residue i; built at elaboration.
	function automatic tbl_t make_tbl(input int unsigned k);
		tbl_t t;
		for (int unsigned i = 0; i < 256; i++) begin
			t[i] = ChanW'((i * k) / NormMax);
		end
		return t;
	endfunction

	localparam tbl_t TblRedY = make_tbl(RedY);
	localparam tbl_t TblRedX = make_tbl(RedX);
	localparam tbl_t TblGrnY = make_tbl(GrnY);
	localparam tbl_t TblBluY = make_tbl(BluY);
	localparam tbl_t TblBluX = make_tbl(BluX);

	// Dimension used for the range test: clamped to the largest frame.
	function automatic logic [DimW-1:0] dim_limit(input logic [DimW-1:0] v);
		return (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
	endfunction

	// Dimension used as divisor: as the range limit, but never zero.
	function automatic logic [DimW-1:0] dim_divisor(input logic [DimW-1:0] v);
		logic [DimW-1:0] l;
		l = dim_limit(v);
		return (l == '0) ? DimW'(1) : l;
	endfunction

	// Restoring division step, DivBits quotient bits. The partial remainder
	// stays below the divisor, so one compare and subtract per bit suffices.
	function automatic div_t div_step(input div_t cur, input logic [DimW-1:0] d);
		div_t         o;
		logic [DimW:0] r;
		o = cur;
		for (int k = 0; k < DivBits; k++) begin
			r    = {o.rem, o.dq[NormW-1]};
			o.dq = {o.dq[NormW-2:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r       = r - {1'b0, d};
				o.dq[0] = 1'b1;
			end
			o.rem = r[DimW-1:0];
		end
		return o;
	endfunction

endpackage

// ===== rtl/gbp_intf.sv =====
// ----------------------------------------------------------------------------
// gbp_pix_if / gbp_res_if: item channels of the gradient background unit
// Valid/ready channels for pixel coordinates and for finished pixels.
// ----------------------------------------------------------------------------
interface gbp_pix_if;
	logic                           valid;
	logic                           ready;
	logic [gbp_pkg::CoordW-1:0]     pixel_x;
	logic [gbp_pkg::CoordW-1:0]     pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gbp_res_if;
	logic                           valid;
	logic                           ready;
	logic [gbp_pkg::IdxW-1:0]       word_index;
	logic [gbp_pkg::ArgbW-1:0]      argb_color;
	logic                           out_of_range;

	modport source (output valid, output word_index, output argb_color,
		output out_of_range, input ready);
	modport sink   (input valid, input word_index, input argb_color,
		input out_of_range, output ready);
endinterface

// ===== rtl/gbp_norm_div.sv =====
// ----------------------------------------------------------------------------
// gbp_norm_div: pipelined restoring divider for one axis
// Divides the scaled coordinate by the frame dimension, two quotient bits
// per stage. Each stage advances on its own enable from the top level.
// ----------------------------------------------------------------------------
module gbp_norm_div (
	input  logic                              clk,
	input  logic [gbp_pkg::NDiv-1:0]          en,
	input  logic [gbp_pkg::NormW-1:0]         dividend,
	input  logic [gbp_pkg::DimW-1:0]          divisor,
	output logic [gbp_pkg::NormW-1:0]         quotient
);

	gbp_pkg::div_t stage_s [gbp_pkg::NDiv];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			stage_s[0] <= gbp_pkg::div_step({{gbp_pkg::DimW{1'b0}}, dividend}, divisor);
		end
		for (int j = 1; j < gbp_pkg::NDiv; j++) begin
			if (en[j]) begin
				stage_s[j] <= gbp_pkg::div_step(stage_s[j-1], divisor);
			end
		end
	end

	// After the last stage the dividend bits have all been replaced by quotient bits.
	assign quotient = stage_s[gbp_pkg::NDiv-1].dq;

endmodule

// ===== rtl/gbp_shade.sv =====
// ----------------------------------------------------------------------------
// gbp_shade: gradient colour from the normalized position
// Three stages: divide by 255 through a reciprocal, weight each axis with a
// coarse product plus a residue table, then sum the channels into ARGB.
// ----------------------------------------------------------------------------
module gbp_shade (
	input  logic                              clk,
	input  logic [2:0]                        en,
	input  logic [gbp_pkg::NormW-1:0]         nx,
	input  logic [gbp_pkg::NormW-1:0]         ny,
	output logic [gbp_pkg::ArgbW-1:0]         argb
);

	localparam int unsigned ProdW = gbp_pkg::NormW + gbp_pkg::RecipW;
	localparam int unsigned CW    = gbp_pkg::ChanW;

	logic [ProdW-1:0] qx_prod, qy_prod;
	logic [CW-1:0]    ax_s1, ay_s1, lx_s1, ly_s1;
	logic [CW-1:0]    bx, by;
	logic [2*CW-1:0]  p_ry, p_rx, p_gy, p_by, p_bx;
	logic [CW-1:0]    ry_s2, rx_s2, gy_s2, by_s2, bx_s2;
	logic [CW-1:0]    red, grn, blu;

	// n = 255 * a + b with b below 255. Channels keep eight bits, so only the
	// low byte of a matters, and b is the low byte of n plus the low byte of a.
	assign qx_prod = ProdW'(nx) * ProdW'(gbp_pkg::RecipM);
	assign qy_prod = ProdW'(ny) * ProdW'(gbp_pkg::RecipM);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ax_s1 <= qx_prod[gbp_pkg::RecipSh +: CW];
			ay_s1 <= qy_prod[gbp_pkg::RecipSh +: CW];
			lx_s1 <= nx[CW-1:0];
			ly_s1 <= ny[CW-1:0];
		end
	end

	// floor(n * k / 255) = k * a + floor(b * k / 255).
	assign bx   = lx_s1 + ax_s1;
	assign by   = ly_s1 + ay_s1;
	assign p_ry = {{CW{1'b0}}, ay_s1} * {{CW{1'b0}}, gbp_pkg::RedY};
	assign p_rx = {{CW{1'b0}}, ax_s1} * {{CW{1'b0}}, gbp_pkg::RedX};
	assign p_gy = {{CW{1'b0}}, ay_s1} * {{CW{1'b0}}, gbp_pkg::GrnY};
	assign p_by = {{CW{1'b0}}, ay_s1} * {{CW{1'b0}}, gbp_pkg::BluY};
	assign p_bx = {{CW{1'b0}}, ax_s1} * {{CW{1'b0}}, gbp_pkg::BluX};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ry_s2 <= p_ry[CW-1:0] + gbp_pkg::TblRedY[by];
			rx_s2 <= p_rx[CW-1:0] + gbp_pkg::TblRedX[bx];
			gy_s2 <= p_gy[CW-1:0] + gbp_pkg::TblGrnY[by];
			by_s2 <= p_by[CW-1:0] + gbp_pkg::TblBluY[by];
			bx_s2 <= p_bx[CW-1:0] + gbp_pkg::TblBluX[bx];
		end
	end

	assign red = gbp_pkg::RedBase - ry_s2 + rx_s2;
	assign grn = gbp_pkg::GrnBase - gy_s2;
	assign blu = gbp_pkg::BluBase - by_s2 + bx_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			argb <= {gbp_pkg::Alpha, red, grn, blu};
		end
	end

endmodule

// ===== rtl/gradient_background_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// gradient_background_pixel_unit: framebuffer index and gradient colour
// Maps one pixel coordinate to its word offset and its opaque ARGB colour.
// ----------------------------------------------------------------------------
// Usage:
// Coordinates enter on the pix channel, one item per cycle at most. Each
// item gives one result on the res channel: the 32-bit word offset
// y * (pitch / 4) + x, the ARGB colour and a flag for coordinates at or
// beyond the frame width or height.
// Each item passes the input stage, the ten-stage divider that normalizes
// each axis and the shading stages; throughput is one item per cycle while
// the receiver keeps res.ready high.
// Frame width, height and line pitch reset to 1024, 768 and 4096 bytes. The unit
// relies on the user to write them on cfg only while no item is in flight.
// Reset empties the pipeline at once. When the receiver stalls, the output
// stage holds its item and stages behind it keep filling their bubbles;
// pix.ready falls only once every stage holds an item.
// ----------------------------------------------------------------------------
module gradient_background_pixel_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gbp_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [gbp_pkg::CfgW-1:0]          cfg_data,
	gbp_pix_if.sink                           pix,
	gbp_res_if.source                         res
);

	localparam int unsigned NSt   = 1 + gbp_pkg::NDiv + 3;
	localparam int unsigned ShdSt = 1 + gbp_pkg::NDiv;
	localparam int unsigned IdxW  = gbp_pkg::IdxW;
	localparam int unsigned DimW  = gbp_pkg::DimW;
	localparam int unsigned NormW = gbp_pkg::NormW;

	// Configuration, kept in the form the datapath needs.
	logic [DimW-1:0]          wlim_q, wdiv_q, hlim_q, hdiv_q;
	logic [gbp_pkg::WplW-1:0] wpl_q;

	logic [NSt-1:0]           valid_s;
	logic [NSt-1:0]           en;

	logic [gbp_pkg::CoordW-1:0] px_s1;
	logic [IdxW-1:0]            wprod_s1;
	logic                       oor_s1;
	logic [NormW-1:0]           dvx_s1, dvy_s1;
	gbp_pkg::side_t             side_s [NSt-1];

	logic [NormW-1:0]           nx, ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlim_q <= gbp_pkg::RstWidth;
			wdiv_q <= gbp_pkg::RstWidth;
			hlim_q <= gbp_pkg::RstHeight;
			hdiv_q <= gbp_pkg::RstHeight;
			wpl_q  <= gbp_pkg::RstWpl;
		end else if (cfg_we) begin
			case (cfg_index)
				gbp_pkg::CfgFrameWidth: begin
					wlim_q <= gbp_pkg::dim_limit(cfg_data[DimW-1:0]);
					wdiv_q <= gbp_pkg::dim_divisor(cfg_data[DimW-1:0]);
				end
				gbp_pkg::CfgFrameHeight: begin
					hlim_q <= gbp_pkg::dim_limit(cfg_data[DimW-1:0]);
					hdiv_q <= gbp_pkg::dim_divisor(cfg_data[DimW-1:0]);
				end
				gbp_pkg::CfgLinePitch: begin
					wpl_q <= cfg_data[gbp_pkg::PitchW-1:2];
				end
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or its content moves on.
	always_comb begin
		en[NSt-1] = !valid_s[NSt-1] || res.ready;
		for (int k = NSt - 2; k >= 0; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	assign pix.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) begin
				valid_s[0] <= pix.valid;
			end
			for (int k = 1; k < NSt; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// Input stage: line offset product, range test, coordinates scaled by 255.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			px_s1    <= pix.pixel_x;
			wprod_s1 <= IdxW'(pix.pixel_y) * IdxW'(wpl_q);
			oor_s1   <= ({1'b0, pix.pixel_x} >= wlim_q) || ({1'b0, pix.pixel_y} >= hlim_q);
			dvx_s1   <= {pix.pixel_x, {gbp_pkg::ChanW{1'b0}}} - NormW'(pix.pixel_x);
			dvy_s1   <= {pix.pixel_y, {gbp_pkg::ChanW{1'b0}}} - NormW'(pix.pixel_y);
		end
	end

	// Word index and range flag ride alongside the divider and shading stages.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s[0].widx <= wprod_s1 + IdxW'(px_s1);
			side_s[0].oor  <= oor_s1;
		end
		for (int k = 2; k < NSt; k++) begin
			if (en[k]) begin
				side_s[k-1] <= side_s[k-2];
			end
		end
	end

	gbp_norm_div u_div_x (
		.clk      (clk),
		.en       (en[gbp_pkg::NDiv:1]),
		.dividend (dvx_s1),
		.divisor  (wdiv_q),
		.quotient (nx)
	);

	gbp_norm_div u_div_y (
		.clk      (clk),
		.en       (en[gbp_pkg::NDiv:1]),
		.dividend (dvy_s1),
		.divisor  (hdiv_q),
		.quotient (ny)
	);

	gbp_shade u_shade (
		.clk  (clk),
		.en   (en[NSt-1:ShdSt]),
		.nx   (nx),
		.ny   (ny),
		.argb (res.argb_color)
	);

	assign res.valid        = valid_s[NSt-1];
	assign res.word_index   = side_s[NSt-2].widx;
	assign res.out_of_range = side_s[NSt-2].oor;

endmodule
